// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check prop at every rising edge of clk outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that trig implies prop at the same edge, outside reset.
`define ASSERT_IMPL(label, clk, rst_n, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
		else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_IMPL(label, clk, rst_n, trig, prop, msg)
`endif

`endif

// File: hdl/clook_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clook_pkg
// Shared defaults for the C-LOOK request orderer.
// ----------------------------------------------------------------------------
package clook_pkg;

	localparam int DEF_MAX_REQUESTS  = 64;
	localparam int DEF_CYLINDER_BITS = 12;

	// Register indexes of the configuration port
	localparam int REG_HEAD_POSITION = 0;

endpackage

// File: hdl/clook_request_orderer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clook_request_orderer
// Collects a batch of cylinder requests and returns them in C-LOOK order.
// ----------------------------------------------------------------------------
//
//  channel  | direction | payload
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | tdata: cylinder, tlast: last_request
//  m_axis   | out       | tdata: cylinder_res, tlast: last_result, tuser: overflowed
//  apb      | in/out    | head_position at byte address 0
//
//  Requests: one whose group is empty is written straight to the store; any
//  other walks past the entries it must pass in its group (insertion into
//  a sorted group, one store entry per cycle). A batch then returns one
//  result at a time, each store read returning before the next is issued.
//  Reset clears the counts, the sequencer and the output valid; the store
//  needs no clearing since only counted entries are ever read.
//  A stalled result holds in the output register; the next batch is taken
//  as soon as the final result of a batch sits there.
//
module clook_request_orderer #(
	parameter int MAX_REQUESTS  = clook_pkg::DEF_MAX_REQUESTS,
	parameter int CYLINDER_BITS = clook_pkg::DEF_CYLINDER_BITS
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// cylinder [CYLINDER_BITS-1:0], zero padding above
	input  logic [((CYLINDER_BITS+7)/8)*8-1:0]       s_axis_tdata,
	input  logic                                     s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  logic                                     s_axis_tlast,
	// cylinder_res [CYLINDER_BITS-1:0], zero padding above
	output logic [((CYLINDER_BITS+7)/8)*8-1:0]       m_axis_tdata,
	output logic                                     m_axis_tvalid,
	input  logic                                     m_axis_tready,
	output logic                                     m_axis_tlast,
	// overflowed [0]
	output logic                                     m_axis_tuser,
	input  logic                                     psel,
	input  logic                                     penable,
	input  logic                                     pwrite,
	input  logic [2:0]                               paddr,
	input  logic [31:0]                              pwdata,
	output logic [31:0]                              prdata,
	output logic                                     pready
);
	import clook_pkg::*;

	localparam int AW = $clog2(MAX_REQUESTS);
	localparam int DW = ((CYLINDER_BITS + 7) / 8) * 8;

	logic [CYLINDER_BITS-1:0] head_q;
	logic                     head_sel;
	logic                     mem_we, mem_re;
	logic [AW-1:0]            mem_waddr, mem_raddr;
	logic [CYLINDER_BITS-1:0] mem_wdata, mem_rdata;
	logic [CYLINDER_BITS-1:0] out_cyl;

	// Configuration: one register, word aligned, writes elsewhere dropped
	assign pready   = 1'b1;
	assign head_sel = (paddr[2] == 1'(REG_HEAD_POSITION));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else if (psel && penable && pwrite && pready && head_sel) begin
			head_q <= pwdata[CYLINDER_BITS-1:0];
		end
	end

	assign prdata = head_sel ? 32'(head_q) : '0;

	// Store holds the upper group ascending from the bottom and the lower
	// group ascending up to the top entry
	clook_store #(
		.MAX_REQUESTS  (MAX_REQUESTS),
		.CYLINDER_BITS (CYLINDER_BITS)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Sequencer: insert each request in order, then walk both groups out
	clook_ctrl #(
		.MAX_REQUESTS  (MAX_REQUESTS),
		.CYLINDER_BITS (CYLINDER_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cyl    (s_axis_tdata[CYLINDER_BITS-1:0]),
		.in_last   (s_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_cyl   (out_cyl),
		.out_last  (m_axis_tlast),
		.out_ovf   (m_axis_tuser),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Pad the result to whole bytes
	assign m_axis_tdata = DW'(out_cyl);

endmodule

// File: hdl/clook_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clook_store
// Request store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module clook_store #(
	parameter int MAX_REQUESTS  = clook_pkg::DEF_MAX_REQUESTS,
	parameter int CYLINDER_BITS = clook_pkg::DEF_CYLINDER_BITS
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(MAX_REQUESTS)-1:0]  waddr,
	input  logic [CYLINDER_BITS-1:0]         wdata,
	input  logic                             re,
	input  logic [$clog2(MAX_REQUESTS)-1:0]  raddr,
	output logic [CYLINDER_BITS-1:0]         rdata
);
	import clook_pkg::*;

	logic [CYLINDER_BITS-1:0] mem_q [MAX_REQUESTS];
	logic [CYLINDER_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/clook_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clook_ctrl
// Insertion sequencer and emitter working on the request store.
// ----------------------------------------------------------------------------
module clook_ctrl #(
	parameter int MAX_REQUESTS  = clook_pkg::DEF_MAX_REQUESTS,
	parameter int CYLINDER_BITS = clook_pkg::DEF_CYLINDER_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [CYLINDER_BITS-1:0]         head,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [CYLINDER_BITS-1:0]         in_cyl,
	input  logic                             in_last,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [CYLINDER_BITS-1:0]         out_cyl,
	output logic                             out_last,
	output logic                             out_ovf,
	output logic                             mem_we,
	output logic [$clog2(MAX_REQUESTS)-1:0]  mem_waddr,
	output logic [CYLINDER_BITS-1:0]         mem_wdata,
	output logic                             mem_re,
	output logic [$clog2(MAX_REQUESTS)-1:0]  mem_raddr,
	input  logic [CYLINDER_BITS-1:0]         mem_rdata
);
	import clook_pkg::*;
	`include "assert_macros.svh"

	localparam int AW = $clog2(MAX_REQUESTS);
	localparam int CW = $clog2(MAX_REQUESTS + 1);
	localparam logic [CW-1:0] MAX_C  = CW'(MAX_REQUESTS);
	localparam logic [AW-1:0] LAST_A = AW'(MAX_REQUESTS - 1);

	typedef enum logic [1:0] {S_IDLE, S_SHIFT, S_PLACE, S_EMIT} state_t;

	state_t                   state_q;
	logic [CW-1:0]            req_cnt_q, upp_cnt_q, emit_k_q;
	logic                     ovf_q, last_q, dir_up_q;
	logic [AW-1:0]            hole_q;
	logic [CYLINDER_BITS-1:0] val_q;
	logic                     rd_pend_s1, rd_last_s1;
	logic                     o_valid_q, o_last_q, o_ovf_q;
	logic [CYLINDER_BITS-1:0] o_cyl_q;

	logic [CW-1:0] lower_cnt;
	logic          in_fire, fits, is_up, grp_empty;
	logic [AW-1:0] hole_a, cmp_a;
	logic          move, at_end;
	logic [AW-1:0] p_a, next_a;
	logic          emit_issue;
	logic [AW-1:0] emit_a;
	logic [CW-1:0] emit_k_inc;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign lower_cnt = req_cnt_q - upp_cnt_q;
	assign fits      = (req_cnt_q < MAX_C);
	assign is_up     = (in_cyl >= head);
	assign grp_empty = is_up ? (upp_cnt_q == '0) : (lower_cnt == '0);
	assign hole_a    = is_up ? AW'(upp_cnt_q) : LAST_A - AW'(lower_cnt);
	assign cmp_a     = is_up ? hole_a - AW'(1) : hole_a + AW'(1);

	// Neighbour of the hole that is being compared in the shift walk
	assign p_a    = dir_up_q ? hole_q - AW'(1) : hole_q + AW'(1);
	assign next_a = dir_up_q ? p_a - AW'(1) : p_a + AW'(1);
	assign move   = dir_up_q ? (mem_rdata > val_q) : (mem_rdata < val_q);
	assign at_end = dir_up_q ? (p_a == '0) : (p_a == LAST_A);

	assign emit_k_inc = emit_k_q + CW'(1);
	assign emit_issue = (state_q == S_EMIT) && !rd_pend_s1 && (emit_k_q < req_cnt_q) &&
		(!o_valid_q || out_ready);
	assign emit_a = (emit_k_q < upp_cnt_q) ? AW'(emit_k_q) :
		AW'(emit_k_q + (MAX_C - req_cnt_q));

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = hole_q;
		mem_wdata = val_q;
		mem_re    = 1'b0;
		mem_raddr = emit_a;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && fits) begin
					if (grp_empty) begin
						mem_we    = 1'b1;
						mem_waddr = hole_a;
						mem_wdata = in_cyl;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = cmp_a;
					end
				end
			end
			S_SHIFT: begin
				mem_we = 1'b1;
				if (move) begin
					mem_wdata = mem_rdata;
					if (!at_end) begin
						mem_re    = 1'b1;
						mem_raddr = next_a;
					end
				end
			end
			S_PLACE: begin
				mem_we = 1'b1;
			end
			S_EMIT: begin
				mem_re = emit_issue;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			req_cnt_q  <= '0;
			upp_cnt_q  <= '0;
			emit_k_q   <= '0;
			ovf_q      <= 1'b0;
			last_q     <= 1'b0;
			dir_up_q   <= 1'b0;
			hole_q     <= '0;
			val_q      <= '0;
			rd_pend_s1 <= 1'b0;
			rd_last_s1 <= 1'b0;
			o_valid_q  <= 1'b0;
			o_cyl_q    <= '0;
			o_last_q   <= 1'b0;
			o_ovf_q    <= 1'b0;
		end else begin
			// Load a fresh result, else drop the held one once taken
			if (rd_pend_s1) begin
				o_valid_q <= 1'b1;
			end else if (out_ready) begin
				o_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						last_q   <= in_last;
						emit_k_q <= '0;
						if (fits) begin
							req_cnt_q <= req_cnt_q + CW'(1);
							if (is_up) begin
								upp_cnt_q <= upp_cnt_q + CW'(1);
							end
							hole_q   <= hole_a;
							val_q    <= in_cyl;
							dir_up_q <= is_up;
							if (!grp_empty) begin
								state_q <= S_SHIFT;
							end else if (in_last) begin
								state_q <= S_EMIT;
							end
						end else begin
							ovf_q <= 1'b1;
							if (in_last) begin
								state_q <= S_EMIT;
							end
						end
					end
				end
				S_SHIFT: begin
					if (move) begin
						hole_q <= p_a;
						if (at_end) begin
							state_q <= S_PLACE;
						end
					end else begin
						state_q <= last_q ? S_EMIT : S_IDLE;
					end
				end
				S_PLACE: begin
					state_q <= last_q ? S_EMIT : S_IDLE;
				end
				S_EMIT: begin
					if (emit_issue) begin
						emit_k_q   <= emit_k_inc;
						rd_pend_s1 <= 1'b1;
						rd_last_s1 <= (emit_k_inc == req_cnt_q);
					end
					if (rd_pend_s1) begin
						rd_pend_s1 <= 1'b0;
						o_cyl_q    <= mem_rdata;
						o_last_q   <= rd_last_s1;
						o_ovf_q    <= ovf_q;
						if (rd_last_s1) begin
							req_cnt_q <= '0;
							upp_cnt_q <= '0;
							ovf_q     <= 1'b0;
							state_q   <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = o_valid_q;
	assign out_cyl   = o_cyl_q;
	assign out_last  = o_last_q;
	assign out_ovf   = o_ovf_q;

	`ASSERT_CLK(a_upper_within_count, clk, arst_n, upp_cnt_q <= req_cnt_q, "upper over count")
	`ASSERT_CLK(a_count_within_store, clk, arst_n, req_cnt_q <= MAX_C, "count beyond store")
	`ASSERT_IMPL(a_no_same_entry, clk, arst_n, mem_we && mem_re, mem_waddr != mem_raddr, "same entry")
	`ASSERT_IMPL(a_load_slot_free, clk, arst_n, rd_pend_s1, !o_valid_q, "result over held one")

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the C-LOOK request orderer. Batches of cylinder
// requests go in on the request stream, and a scoreboard built beside the
// bench works out the service order. The scoreboard keeps the upper group
// (at or above the head) and the lower group in ascending order. Each result
// on the output stream is matched field by field against that order.
// ----------------------------------------------------------------------------
module tb;

	import clook_pkg::*;

	localparam int MAX_REQ       = DEF_MAX_REQUESTS;
	localparam int CYL_BITS      = DEF_CYLINDER_BITS;
	localparam int DATA_W        = ((CYL_BITS + 7) / 8) * 8;
	localparam int REG_SPARE     = REG_HEAD_POSITION + 1;	// unmapped register slot
	localparam int MAX_GAP       = 13;
	// Worst insertion walks the whole store, then the results drain
	localparam int SETTLE_CYCLES = 2 * MAX_REQ + 16;
	localparam int IDLE_LIMIT    = 4000;
	localparam int RANDOM_ITEMS  = 20;

	typedef logic [CYL_BITS-1:0] cyl_t;

	typedef struct packed {
		cyl_t cylinder;
		logic final_flag;
		logic overflowed;
	} service_slot_t;

	// ------------------------------------------------------------------------
	// DUT connections
	// ------------------------------------------------------------------------
	logic              clk;
	logic              arst_n;
	logic [DATA_W-1:0] s_axis_tdata;	// cylinder [11:0], zero padding above
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic              s_axis_tlast;	// last_request
	logic [DATA_W-1:0] m_axis_tdata;	// cylinder_res [11:0], zero padding above
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic              m_axis_tlast;	// last_result
	logic              m_axis_tuser;	// overflowed [0]
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [2:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	clook_request_orderer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// ------------------------------------------------------------------------
	// Scoreboard state: our own copy of the head register and both groups,
	// each kept sorted as requests arrive so the close only has to read out.
	// ------------------------------------------------------------------------
	cyl_t          head_reg;
	cyl_t          upper_group[$];
	cyl_t          lower_group[$];
	bit            dropped_flag;
	service_slot_t expected_order[$];

	// Idle control: the largest gap each side may draw per item
	int src_gap_max;
	int sink_gap_max;

	// Run statistics
	int error_count;
	int requests_sent;
	int batches_closed;
	int overflow_batches;
	int results_checked;
	int config_writes;
	int idle_cycles;

	// ------------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------------
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Mismatch reporting: one line per failure, and count it
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		error_count++;
	endtask

	// ------------------------------------------------------------------------
	// Service-order prediction for one accepted request
	// ------------------------------------------------------------------------
	function automatic void order_request(input cyl_t cyl, input logic closing);
		int            pos;
		int            total;
		service_slot_t slot;
		// Store the request in its group, or drop it when the store is full
		if (upper_group.size() + lower_group.size() < MAX_REQ) begin
			pos = 0;
			if (cyl >= head_reg) begin
				while (pos < upper_group.size() && upper_group[pos] <= cyl) pos++;
				upper_group.insert(pos, cyl);
			end else begin
				while (pos < lower_group.size() && lower_group[pos] <= cyl) pos++;
				lower_group.insert(pos, cyl);
			end
		end else begin
			dropped_flag = 1'b1;
		end
		if (!closing)
			return;
		// Close: upper group first, then wrap round to the lowest cylinder
		total = upper_group.size() + lower_group.size();
		for (int k = 0; k < total; k++) begin
			slot.cylinder   = (k < upper_group.size()) ? upper_group[k]
				: lower_group[k - upper_group.size()];
			slot.final_flag = (k == total - 1);
			slot.overflowed = dropped_flag;
			expected_order.push_back(slot);
		end
		batches_closed++;
		if (dropped_flag)
			overflow_batches++;
		upper_group.delete();
		lower_group.delete();
		dropped_flag = 1'b0;
	endfunction

	// ------------------------------------------------------------------------
	// Send one request item. Valid stays high after acceptance so that a
	// back-to-back item simply replaces the data on the next call.
	// ------------------------------------------------------------------------
	task automatic send_request(input cyl_t cyl, input logic closing);
		int gap;
		gap = $urandom_range(0, src_gap_max);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata  <= DATA_W'(cyl);
		s_axis_tlast  <= closing;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		order_request(cyl, closing);
		requests_sent++;
	endtask

	// Drop valid, drain every outstanding result, then allow the block to
	// finish any insertion it may still be walking.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_order.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle held until pready
	task automatic write_register(input int index, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'(index * 4);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (index == REG_HEAD_POSITION)
			head_reg = value[CYL_BITS-1:0];
		config_writes++;
	endtask

	// Change the head while idle; junk in the upper bits must be ignored
	task automatic set_head(input cyl_t head);
		logic [31:0] word;
		word = $urandom;
		word[CYL_BITS-1:0] = head;
		wait_idle();
		write_register(REG_HEAD_POSITION, word);
	endtask

	// Cylinder biased towards the interesting spots around the split
	function automatic cyl_t pick_cylinder();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return head_reg;
			3:       return head_reg - 1'b1;
			4:       return head_reg + 1'b1;
			default: return cyl_t'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Result sink: draw a stall per result, then hold ready until it is taken
	// ------------------------------------------------------------------------
	initial begin : sink_driver
		int gap;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = $urandom_range(0, sink_gap_max);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	// ------------------------------------------------------------------------
	// Result checker: compare every accepted result with the oldest expectation
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		service_slot_t slot;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_order.size() == 0) begin
				report_mismatch("unexpected result", 32'(m_axis_tdata), 32'hFFFF_FFFF);
			end else begin
				slot = expected_order.pop_front();
				if (m_axis_tdata !== DATA_W'(slot.cylinder))
					report_mismatch("cylinder_res", 32'(m_axis_tdata), 32'(slot.cylinder));
				if (m_axis_tlast !== slot.final_flag)
					report_mismatch("last_result", 32'(m_axis_tlast), 32'(slot.final_flag));
				if (m_axis_tuser !== slot.overflowed)
					report_mismatch("overflowed", 32'(m_axis_tuser), 32'(slot.overflowed));
			end
			results_checked++;
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: end the run if nothing moves on any port for too long
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : watchdog
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (psel && penable && pwrite && pready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("[%0t] watchdog: no progress for %0d cycles", $realtime, IDLE_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Directed cases: field extremes, the split at head, a lone closing
	// request, and a write to the unmapped slot
	// ------------------------------------------------------------------------
	task automatic test_directed();
		src_gap_max  = MAX_GAP;
		sink_gap_max = MAX_GAP;
		// Head at reset value: a batch of one, then all in the upper group
		send_request('1, 1'b1);
		send_request('0, 1'b0);
		send_request('1, 1'b0);
		send_request(cyl_t'(12'h800), 1'b1);
		// Split in the middle, with requests on and either side of the head
		set_head(cyl_t'(12'h800));
		send_request(cyl_t'(12'h7FF), 1'b0);
		send_request(cyl_t'(12'h800), 1'b0);
		send_request('1, 1'b0);
		send_request('0, 1'b0);
		send_request(cyl_t'(12'h801), 1'b0);
		send_request(cyl_t'(12'h001), 1'b0);
		send_request(cyl_t'(12'h800), 1'b1);
		// Head at the top: only the top cylinder lands in the upper group
		set_head('1);
		send_request(cyl_t'(12'hFFE), 1'b0);
		send_request('1, 1'b0);
		send_request('0, 1'b1);
		// The unmapped slot must leave the head alone
		wait_idle();
		write_register(REG_SPARE, 32'hFFFF_FFFF);
		send_request(cyl_t'(12'hAAA), 1'b0);
		send_request(cyl_t'(12'h555), 1'b1);
		set_head('0);
	endtask

	// ------------------------------------------------------------------------
	// Store overflow: a batch past capacity whose closing request is itself
	// dropped
	// ------------------------------------------------------------------------
	task automatic test_overflow();
		src_gap_max  = 2;
		sink_gap_max = MAX_GAP;
		set_head(cyl_t'($urandom));
		for (int i = 0; i < MAX_REQ + 3; i++)
			send_request(pick_cylinder(), i == MAX_REQ + 2);
	endtask

	// ------------------------------------------------------------------------
	// Random batches: mostly short, now and then longer, with the head moved
	// between batches and the idling switched between busy and quiet stretches
	// ------------------------------------------------------------------------
	task automatic test_random();
		int sent;
		int len;
		cyl_t head;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 3))
					0:       head = '0;
					1:       head = '1;
					default: head = cyl_t'($urandom);
				endcase
				set_head(head);
			end
			src_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
			sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 6);
			for (int i = 0; i < len; i++)
				send_request(pick_cylinder(), i == len - 1);
			sent += len;
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : main_sequence
		// Hold every input at a known value through reset
		arst_n        = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tlast  = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		head_reg      = '0;
		dropped_flag  = 1'b0;
		src_gap_max   = 0;
		sink_gap_max  = 0;
		error_count      = 0;
		requests_sent    = 0;
		batches_closed   = 0;
		overflow_batches = 0;
		results_checked  = 0;
		config_writes    = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_overflow();
		test_random();

		// Drain what is left, then give stray results time to show up
		wait_idle();
		if (expected_order.size() != 0)
			report_mismatch("results never returned", 32'(expected_order.size()), 32'd0);

		$display("Sent %0d requests in %0d batches, %0d of them past store capacity.",
			requests_sent, batches_closed, overflow_batches);
		$display("Checked %0d ordered results across %0d register writes.",
			results_checked, config_writes);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
